/* rtl/bie_pkg.sv */
package bie_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned EncWidth   = 13;
  localparam int unsigned LogWidth   = 3;
  localparam int unsigned CountWidth = 7;
  localparam int unsigned FieldWidth = 6;

  localparam logic [LogWidth-1:0] LogSize64 = 3'd6;
  localparam logic [LogWidth-1:0] LogSize32 = 3'd5;
  localparam logic [LogWidth-1:0] LogSize16 = 3'd4;
  localparam logic [LogWidth-1:0] LogSize8  = 3'd3;
  localparam logic [LogWidth-1:0] LogSize4  = 3'd2;
  localparam logic [LogWidth-1:0] LogSize2  = 3'd1;

  typedef struct packed {
    logic [ValueWidth-1:0] imm_value;
    logic                  is_64bit;
  } bie_in_t;

  typedef struct packed {
    logic                encodable;
    logic [EncWidth-1:0] encoding;
  } bie_out_t;

  typedef struct packed {
    logic                  reject;
    logic [LogWidth-1:0]   lsize;
    logic [ValueWidth-1:0] elem;
    logic [ValueWidth-1:0] mask;
  } bie_s1_t;

  typedef struct packed {
    logic                  reject;
    logic [LogWidth-1:0]   lsize;
    logic                  run_a;
    logic                  run_b;
    logic [FieldWidth-1:0] tz;
    logic [FieldWidth-1:0] t1;
    logic [FieldWidth-1:0] lz;
    logic [CountWidth-1:0] lo;
  } bie_s2_t;

endpackage

/* rtl/bitmask_immediate_encoder.sv */
// Checks whether a 64-bit value is a logical-instruction bitmask immediate for a 32-bit or
// 64-bit register and returns its N:immr:imms encoding, or zero with encodable low when it is
// not one. The block is a three-stage pipeline: the first stage finds the element size by
// comparing halves and screens out the rejected values, the second counts trailing zeros,
// trailing ones, leading zeros and leading ones of the element and checks for a single run,
// and the third forms the fields into the output register. It takes one item per cycle while the
// output is not stalled, and a stall at the output holds each full stage whose next stage is also
// full, while empty stages still take items.
module bitmask_immediate_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bie_pkg::bie_in_t   in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bie_pkg::bie_out_t  out_o
);
  import bie_pkg::*;

  function automatic logic low_run(input logic [ValueWidth-1:0] x);
    low_run = (x != '0) && (((x + 64'd1) & x) == '0);
  endfunction

  function automatic logic one_run(input logic [ValueWidth-1:0] x);
    one_run = (x != '0) && low_run((x - 64'd1) | x);
  endfunction

  function automatic logic [FieldWidth-1:0] trail_zeros(input logic [ValueWidth-1:0] x);
    logic [FieldWidth-1:0] n;
    n = '0;
    for (int i = ValueWidth - 1; i >= 0; i--) begin
      if (x[i]) begin
        n = FieldWidth'(i);
      end
    end
    trail_zeros = n;
  endfunction

  function automatic logic [CountWidth-1:0] lead_ones(input logic [ValueWidth-1:0] x);
    logic [CountWidth-1:0] n;
    n = CountWidth'(ValueWidth);
    for (int i = 0; i < ValueWidth; i++) begin
      if (!x[i]) begin
        n = CountWidth'(ValueWidth - 1 - i);
      end
    end
    lead_ones = n;
  endfunction

  logic     v1_q, v2_q, v3_q;
  logic     en1, en2, en3;
  bie_s1_t  s1_d, s1_q;
  bie_s2_t  s2_d, s2_q;
  bie_out_t s3_d, s3_q;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  logic [ValueWidth-1:0] val;
  logic                  wide;
  logic                  eq1, eq2, eq3, eq4, eq5;
  logic [LogWidth-1:0]   lsize;
  logic [ValueWidth-1:0] mask;

  always_comb begin
    val  = in_i.imm_value;
    wide = in_i.is_64bit;
    eq5  = val[31:0] == val[63:32];
    eq4  = val[15:0] == val[31:16];
    eq3  = val[7:0]  == val[15:8];
    eq2  = val[3:0]  == val[7:4];
    eq1  = val[1:0]  == val[3:2];
    priority if (wide && !eq5) begin
      lsize = LogSize64;
    end else if (!eq4) begin
      lsize = LogSize32;
    end else if (!eq3) begin
      lsize = LogSize16;
    end else if (!eq2) begin
      lsize = LogSize8;
    end else if (!eq1) begin
      lsize = LogSize4;
    end else begin
      lsize = LogSize2;
    end
    mask = ~(64'hffff_ffff_ffff_fffe << ((7'd1 << lsize) - 7'd1));
    s1_d.reject = (val == '0) || (val == '1) ||
                  (!wide && ((val[63:32] != '0) || (val[31:0] == '0) ||
                             (val[31:0] == '1)));
    s1_d.lsize  = lsize;
    s1_d.elem   = val & mask;
    s1_d.mask   = mask;
  end

  always_comb begin
    s2_d.reject = s1_q.reject;
    s2_d.lsize  = s1_q.lsize;
    s2_d.run_a  = one_run(s1_q.elem);
    s2_d.run_b  = one_run(~s1_q.elem & s1_q.mask);
    s2_d.tz     = trail_zeros(s1_q.elem);
    s2_d.t1     = trail_zeros(~s1_q.elem);
    s2_d.lz     = FieldWidth'(lead_ones(~s1_q.elem));
    s2_d.lo     = lead_ones(s1_q.elem | ~s1_q.mask);
  end

  logic [FieldWidth-1:0] size_m1;
  logic [FieldWidth-1:0] immr;
  logic [FieldWidth-1:0] imms;
  logic [FieldWidth-1:0] run_m1;
  logic                  n_bit;
  logic                  ok;

  always_comb begin
    size_m1 = FieldWidth'((7'd1 << s2_q.lsize) - 7'd1);
    if (s2_q.run_a) begin
      immr   = (6'd0 - s2_q.tz) & size_m1;
      run_m1 = ~s2_q.lz - s2_q.tz;
    end else begin
      immr   = s2_q.lo[FieldWidth-1:0] & size_m1;
      run_m1 = s2_q.lo[FieldWidth-1:0] + s2_q.t1 + size_m1;
    end
    imms  = {~size_m1[4:0], 1'b0} | run_m1;
    n_bit = s2_q.lsize == LogSize64;
    ok    = !s2_q.reject && (s2_q.run_a || s2_q.run_b);
    s3_d.encodable = ok;
    s3_d.encoding  = ok ? {n_bit, immr, imms} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (en2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (en3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_o       = s3_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("Input stalled while the output is free.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.encodable) |-> (out_o.encoding == '0))
    else $error("Rejected item carries a nonzero encoding.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !s1_q.reject) |-> (s1_q.elem != '0 && s1_q.elem != s1_q.mask))
    else $error("Accepted element is all zeros or all ones.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en2) |=> (v2_q && $stable(s2_q)))
    else $error("Stalled middle stage lost or changed its item.");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import bie_pkg::*;

  localparam int unsigned NumProbes  = 25;
  localparam int unsigned NumRandom  = 1400;
  localparam int unsigned TailItems  = 200;
  localparam int unsigned StallLimit = 500;
  localparam int unsigned MaxReports = 10;
  localparam logic [ValueWidth-1:0] AllOnes = '1;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic                  wide;
    logic                  typed;
    logic                  ok;
    logic [EncWidth-1:0]   code;
  } probe_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  bie_in_t  in_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  bie_out_t out_o;

  bie_out_t    pending_codes[$];
  bie_out_t    head_code;
  bit          calm = 1'b0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned codes_seen = 0;
  int unsigned rejects_seen = 0;
  int unsigned quiet_cycles = 0;

  // Rows marked typed carry an expectation that is plain from the encoding rules.
  probe_row_t probe_rows [NumProbes] = '{
    '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0, 13'h0000},
    '{64'h0000_0000_0000_0000, 1'b0, 1'b1, 1'b0, 13'h0000},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 13'h0000},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0, 13'h0000},
    '{64'h0000_0001_0000_0001, 1'b0, 1'b1, 1'b0, 13'h0000},
    '{64'h0000_0000_FFFF_FFFF, 1'b0, 1'b1, 1'b0, 13'h0000},
    '{64'hFFFF_FFFF_0000_0000, 1'b0, 1'b1, 1'b0, 13'h0000},
    '{64'h0000_0000_0000_0001, 1'b1, 1'b1, 1'b1, 13'h1000},
    '{64'h0000_0000_0000_0001, 1'b0, 1'b1, 1'b1, 13'h0000},
    '{64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b1, 13'h003C},
    '{64'h0000_0000_5555_5555, 1'b0, 1'b0, 1'b0, 13'h0000},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0, 13'h0000},
    '{64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 13'h0000},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 13'h0000},
    '{64'h8000_0000_0000_0001, 1'b1, 1'b0, 1'b0, 13'h0000},
    '{64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 13'h0000},
    '{64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b0, 1'b0, 13'h0000},
    '{64'h3333_3333_3333_3333, 1'b1, 1'b0, 1'b0, 13'h0000},
    '{64'h00FF_00FF_00FF_00FF, 1'b1, 1'b0, 1'b0, 13'h0000},
    '{64'h0000_FFFF_0000_FFFF, 1'b1, 1'b0, 1'b0, 13'h0000},
    '{64'h0000_0000_7FFF_FFFE, 1'b0, 1'b0, 1'b0, 13'h0000},
    '{64'h0000_0000_FFFF_FFFE, 1'b0, 1'b0, 1'b0, 13'h0000},
    '{64'h0000_0000_8000_0001, 1'b0, 1'b0, 1'b0, 13'h0000},
    '{64'h0000_0000_0000_0005, 1'b1, 1'b1, 1'b0, 13'h0000},
    '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0, 1'b0, 13'h0000}
  };

  bitmask_immediate_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned count_trailing_zeros(logic [ValueWidth-1:0] x);
    int unsigned n;
    n = 0;
    while (n < ValueWidth && !x[n]) n++;
    return n;
  endfunction

  function automatic int unsigned count_leading_ones(logic [ValueWidth-1:0] x);
    int unsigned n;
    n = 0;
    while (n < ValueWidth && x[ValueWidth-1-n]) n++;
    return n;
  endfunction

  function automatic bit is_low_run(logic [ValueWidth-1:0] x);
    return x != '0 && ((x + 64'd1) & x) == '0;
  endfunction

  function automatic bit is_single_run(logic [ValueWidth-1:0] x);
    return x != '0 && is_low_run((x - 64'd1) | x);
  endfunction

  function automatic bie_out_t encode_bitmask(logic [ValueWidth-1:0] value, logic wide);
    bie_out_t              res;
    int unsigned           size, rot, run_len, immr, lead;
    logic [ValueWidth-1:0] v, half_mask, elem_mask, nimms;
    bit                    split;
    res = '0;
    v = value;
    if (v == '0 || v == AllOnes) return res;
    if (!wide && (v[63:32] != '0 || v[31:0] == '0 || v[31:0] == 32'hFFFF_FFFF)) return res;
    size = wide ? 64 : 32;
    split = 1'b0;
    while (!split && size > 2) begin
      size = size >> 1;
      half_mask = (64'd1 << size) - 64'd1;
      if ((v & half_mask) != ((v >> size) & half_mask)) begin
        size = size << 1;
        split = 1'b1;
      end
    end
    elem_mask = AllOnes >> (64 - size);
    v = v & elem_mask;
    if (is_single_run(v)) begin
      rot = count_trailing_zeros(v);
      run_len = count_trailing_zeros(~(v >> rot));
    end else begin
      v = v | ~elem_mask;
      if (!is_single_run(~v)) return res;
      lead = count_leading_ones(v);
      rot = 64 - lead;
      run_len = lead + count_trailing_zeros(~v) - (64 - size);
    end
    immr = (size - rot) & (size - 1);
    nimms = (~64'(size - 1)) << 1;
    nimms = nimms | 64'(run_len - 1);
    res.encodable = 1'b1;
    res.encoding = {~nimms[6], immr[5:0], nimms[5:0]};
    return res;
  endfunction

  function automatic logic [ValueWidth-1:0] replicate_run(int unsigned size, int unsigned run,
                                                          int unsigned rot, int unsigned span);
    logic [ValueWidth-1:0] elem, mask, v;
    int unsigned           i;
    mask = AllOnes >> (64 - size);
    elem = (64'd1 << run) - 64'd1;
    if (rot != 0) elem = ((elem << rot) | (elem >> (size - rot))) & mask;
    v = '0;
    for (i = 0; i < span; i += size) v = v | (elem << i);
    return v;
  endfunction

  // Mostly valid patterns, the rest damaged patterns, raw noise and the corner values.
  function automatic bie_in_t random_item();
    bie_in_t     item;
    int unsigned kind, lsz, size, run, rot, pos;
    logic        wide;
    kind = $urandom_range(0, 9);
    wide = 1'($urandom_range(0, 1));
    lsz = $urandom_range(1, wide ? 6 : 5);
    size = 1 << lsz;
    run = $urandom_range(1, size - 1);
    rot = $urandom_range(0, size - 1);
    item.is_64bit = wide;
    item.imm_value = replicate_run(size, run, rot, wide ? 64 : 32);
    case (kind)
      6: begin
        pos = $urandom_range(0, 63);
        item.imm_value[pos] = ~item.imm_value[pos];
      end
      7: item.imm_value = {$urandom, $urandom};
      8: begin
        item.is_64bit = 1'b0;
        item.imm_value[63:32] = $urandom;
        if ($urandom_range(0, 1) == 1) begin
          item.imm_value[31:0] = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
        end
      end
      9: begin
        case ($urandom_range(0, 2))
          0: item.imm_value = '0;
          1: item.imm_value = AllOnes;
          default: item.imm_value = 64'h0000_0000_FFFF_FFFF;
        endcase
      end
      default: ;
    endcase
    return item;
  endfunction

  task automatic send_item(bie_in_t item, bie_out_t want);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_codes.push_back(want);
    items_sent++;
  endtask

  initial begin
    int unsigned idx;
    bie_in_t     item;
    bie_out_t    want;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (idx = 0; idx < NumProbes; idx++) begin
      item.imm_value = probe_rows[idx].value;
      item.is_64bit = probe_rows[idx].wide;
      if (probe_rows[idx].typed) begin
        want.encodable = probe_rows[idx].ok;
        want.encoding = probe_rows[idx].code;
      end else begin
        want = encode_bitmask(item.imm_value, item.is_64bit);
      end
      send_item(item, want);
    end
    for (idx = 0; idx < NumRandom; idx++) begin
      calm = (idx >= NumRandom - TailItems) || ((idx / 64) % 4 == 3);
      item = random_item();
      send_item(item, encode_bitmask(item.imm_value, item.is_64bit));
    end
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d items through both register widths and all element sizes.", items_sent);
    $display("Results: %0d encodable, %0d rejected, %0d errors.", codes_seen, rejects_seen,
             errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_codes.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("Unexpected result: encodable=%0b encoding=%h", out_o.encodable,
                   out_o.encoding);
        end
      end else begin
        head_code = pending_codes.pop_front();
        if (out_o.encodable !== head_code.encodable || out_o.encoding !== head_code.encoding) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("Mismatch: expected encodable=%0b encoding=%h, got encodable=%0b encoding=%h",
                     head_code.encodable, head_code.encoding, out_o.encodable, out_o.encoding);
          end
        end
        if (head_code.encodable) begin
          codes_seen++;
        end else begin
          rejects_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
